// File: hw/rtl/sensor_frame_parser_with_sum_check_unit_macros.svh
`ifndef SENSOR_FRAME_PARSER_WITH_SUM_CHECK_UNIT_MACROS_SVH
`define SENSOR_FRAME_PARSER_WITH_SUM_CHECK_UNIT_MACROS_SVH

// plain property, clocked on clk_i, off during reset
`define SFPSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// implication form, consequent checked in the cycle after the antecedent
`define SFPSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/sfpsc_pkg.sv
package sfpsc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SumW   = 16;
  localparam int unsigned LevelW = 32;
  localparam int unsigned PosW   = 4;
  localparam int unsigned CfgIdxW = 1;

  localparam logic [PosW-1:0] PosStart   = 4'd0;
  localparam logic [PosW-1:0] PosAction  = 4'd1;
  localparam logic [PosW-1:0] PosSrcLast = 4'd5;
  localparam logic [PosW-1:0] PosClnLast = 4'd9;
  localparam logic [PosW-1:0] PosTemp    = 4'd10;
  localparam logic [PosW-1:0] SumBytes   = 4'd11;
  localparam logic [PosW-1:0] FrameLast  = 4'd12;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START  = 1'b0,
    CFG_ACTION = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [ByteW-1:0] start_byte;
    logic [ByteW-1:0] action_byte;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [ByteW-1:0] data;
  } byte_word_t;

  typedef struct packed {
    logic [LevelW-1:0] source_level;
    logic [LevelW-1:0] clean_level;
    logic [ByteW-1:0]  temp_reading;
    logic              sum_ok;
  } result_t;

endpackage

// File: hw/rtl/sensor_frame_parser_with_sum_check_unit.sv
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+----------------------------------------------
// in       | in_valid_i  | in_stall_o  | rx_byte_i
// out      | out_valid_o | out_stall_i | source_level_o clean_level_o temp_reading_o
//          |             |             | sum_ok_o
// cfg      | cfg_we_i    | -           | cfg_index_i cfg_wdata_i
//
// one word per cycle sustained, except while the final byte of a frame waits on a held result;
// a result on the 13th byte passes the input register, then parser state and result register
// reset clears frame position, running sum, valid flags and both config registers
// bytes that give no result keep flowing while a result is held by out_stall_i;
// only the final byte of a frame waits for the result register
module sensor_frame_parser_with_sum_check_unit
  import sfpsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [LevelW-1:0]  source_level_o,
  output logic [LevelW-1:0]  clean_level_o,
  output logic [ByteW-1:0]   temp_reading_o,
  output logic               sum_ok_o
);

  cfg_t       cfg;
  byte_word_t word;
  logic       consume;
  result_t    result;

  sfpsc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  sfpsc_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .word_o     (word),
    .consume_i  (consume)
  );

  sfpsc_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .word_i      (word),
    .consume_o   (consume),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (result)
  );

  assign source_level_o = result.source_level;
  assign clean_level_o  = result.clean_level;
  assign temp_reading_o = result.temp_reading;
  assign sum_ok_o       = result.sum_ok;

endmodule

// File: hw/rtl/sfpsc_cfg_regs.sv
module sfpsc_cfg_regs
  import sfpsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  output cfg_t               cfg_o
);

  cfg_t cfg_q;
  cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_START:  cfg_d.start_byte  = cfg_wdata_i;
        CFG_ACTION: cfg_d.action_byte = cfg_wdata_i;
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hw/rtl/sfpsc_in_stage.sv
module sfpsc_in_stage
  import sfpsc_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [ByteW-1:0] rx_byte_i,
  output byte_word_t       word_o,
  input  logic             consume_i
);

  logic             valid_q;
  logic             valid_d;
  logic [ByteW-1:0] data_q;
  logic             take;

  assign in_stall_o = valid_q && !consume_i;
  assign take       = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (consume_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q <= rx_byte_i;
    end
  end

  assign word_o.valid = valid_q;
  assign word_o.data  = data_q;

endmodule

// File: hw/rtl/sfpsc_parser.sv
module sfpsc_parser
  import sfpsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  byte_word_t word_i,
  output logic       consume_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output result_t    result_o
);

`include "sensor_frame_parser_with_sum_check_unit_macros.svh"

  logic [PosW-1:0]   pos_q, pos_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [LevelW-1:0] src_q, src_d;
  logic [LevelW-1:0] cln_q, cln_d;
  logic [ByteW-1:0]  temp_q, temp_d;
  logic [ByteW-1:0]  hi_q, hi_d;
  logic              out_valid_q, out_valid_d;
  result_t           res_q;
  result_t           res_d;
  logic              at_final;
  logic              emit;
  logic [ByteW-1:0]  b;
  logic [SumW-1:0]   sum_add;

  assign b         = word_i.data;
  assign at_final  = (pos_q >= FrameLast);
  assign consume_o = word_i.valid && (!at_final || !out_valid_q || !out_stall_i);
  assign emit      = consume_o && at_final;
  assign sum_add   = sum_q + {{(SumW-ByteW){1'b0}}, b};

  always_comb begin
    pos_d  = pos_q;
    sum_d  = sum_q;
    src_d  = src_q;
    cln_d  = cln_q;
    temp_d = temp_q;
    hi_d   = hi_q;
    if (consume_o) begin
      if (pos_q == PosStart) begin
        if (b == cfg_i.start_byte) begin
          sum_d = {{(SumW-ByteW){1'b0}}, b};
          pos_d = PosAction;
        end
      end else if (pos_q == PosAction) begin
        if (b != cfg_i.action_byte) begin
          pos_d = PosStart;
          sum_d = '0;
        end else begin
          sum_d = sum_add;
          pos_d = pos_q + 4'd1;
        end
      end else if (!at_final) begin
        if (pos_q < SumBytes) begin
          sum_d = sum_add;
        end
        if (pos_q <= PosSrcLast) begin
          src_d = {src_q[LevelW-ByteW-1:0], b};
        end else if (pos_q <= PosClnLast) begin
          cln_d = {cln_q[LevelW-ByteW-1:0], b};
        end else if (pos_q == PosTemp) begin
          temp_d = b;
        end else begin
          hi_d = b;
        end
        pos_d = pos_q + 4'd1;
      end else begin
        pos_d = PosStart;
        sum_d = '0;
      end
    end
  end

  always_comb begin
    res_d              = res_q;
    out_valid_d        = out_valid_q && out_stall_i;
    if (emit) begin
      out_valid_d        = 1'b1;
      res_d.source_level = src_q;
      res_d.clean_level  = cln_q;
      res_d.temp_reading = temp_q;
      res_d.sum_ok       = ({hi_q, b} == sum_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= PosStart;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pos_q       <= pos_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    cln_q  <= cln_d;
    temp_q <= temp_d;
    hi_q   <= hi_d;
    res_q  <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `SFPSC_ASSERT(a_pos_range, pos_q <= FrameLast, "frame position out of range")
  `SFPSC_ASSERT_NEXT(a_final_clears, emit, (pos_q == PosStart) && (sum_q == '0),
                     "frame state not cleared after last byte")
  `SFPSC_ASSERT_NEXT(a_bad_start, consume_o && (pos_q == PosStart) && (b != cfg_i.start_byte),
                     pos_q == PosStart, "wrong start byte advanced the frame")
  `SFPSC_ASSERT(a_result_source, out_valid_q && !$past(out_valid_q) |-> $past(emit),
                "result appeared without a final byte")

endmodule

// File: dv/sfpsc_frame_checker.sv
module sfpsc_frame_checker
  import sfpsc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [ByteW-1:0]   cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [ByteW-1:0]   rx_byte_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [LevelW-1:0]  source_level_i,
  input  logic [LevelW-1:0]  clean_level_i,
  input  logic [ByteW-1:0]   temp_reading_i,
  input  logic               sum_ok_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        frames_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t             cfg_q;
  logic [PosW-1:0]  frame_pos;
  logic [SumW-1:0]  sum_acc;
  logic [LevelW-1:0] src_acc;
  logic [LevelW-1:0] cln_acc;
  logic [ByteW-1:0] temp_acc;
  logic [ByteW-1:0] sum_hi;
  result_t          frames_q[$];
  result_t          oldest;

  task automatic report_mismatch(input string what, input logic [LevelW-1:0] got,
                                 input logic [LevelW-1:0] want);
    if (mismatch_cnt_o < 100) begin
      $display("%0t mismatch %s: got %h want %h", $realtime, what, got, want);
    end
    mismatch_cnt_o++;
  endtask

  task automatic parse_byte(input logic [ByteW-1:0] b);
    result_t r;
    if (frame_pos == PosStart) begin
      if (b == cfg_q.start_byte) begin
        sum_acc   = SumW'(b);
        frame_pos = PosAction;
      end
    end else if (frame_pos == PosAction) begin
      if (b == cfg_q.action_byte) begin
        sum_acc   = sum_acc + SumW'(b);
        frame_pos = PosAction + 1'b1;
      end else begin
        sum_acc   = '0;
        frame_pos = PosStart;
      end
    end else if (frame_pos < FrameLast) begin
      if (frame_pos < SumBytes) begin
        sum_acc = sum_acc + SumW'(b);
      end
      if (frame_pos <= PosSrcLast) begin
        src_acc = {src_acc[LevelW-ByteW-1:0], b};
      end else if (frame_pos <= PosClnLast) begin
        cln_acc = {cln_acc[LevelW-ByteW-1:0], b};
      end else if (frame_pos == PosTemp) begin
        temp_acc = b;
      end else begin
        sum_hi = b;
      end
      frame_pos = frame_pos + 1'b1;
    end else begin
      r.source_level = src_acc;
      r.clean_level  = cln_acc;
      r.temp_reading = temp_acc;
      r.sum_ok       = ({sum_hi, b} == sum_acc);
      frames_q = {frames_q, r};
      sum_acc   = '0;
      frame_pos = PosStart;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q            = '0;
      frame_pos        = PosStart;
      sum_acc          = '0;
      src_acc          = '0;
      cln_acc          = '0;
      temp_acc         = '0;
      sum_hi           = '0;
      frames_q.delete();
      mismatch_cnt_o   = 0;
      frames_pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (frames_q.size() == 0) begin
          report_mismatch("result with no frame pending", '0, '0);
        end else begin
          oldest = frames_q.pop_front();
          if (source_level_i !== oldest.source_level) begin
            report_mismatch("source_level", source_level_i, oldest.source_level);
          end
          if (clean_level_i !== oldest.clean_level) begin
            report_mismatch("clean_level", clean_level_i, oldest.clean_level);
          end
          if (temp_reading_i !== oldest.temp_reading) begin
            report_mismatch("temp_reading", LevelW'(temp_reading_i),
                            LevelW'(oldest.temp_reading));
          end
          if (sum_ok_i !== oldest.sum_ok) begin
            report_mismatch("sum_ok", LevelW'(sum_ok_i), LevelW'(oldest.sum_ok));
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_index_i))
          CFG_START:  cfg_q.start_byte = cfg_wdata_i;
          CFG_ACTION: cfg_q.action_byte = cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        parse_byte(rx_byte_i);
      end
      frames_pending_o <= frames_q.size();
    end
  end

endmodule

// File: dv/sensor_frame_parser_with_sum_check_unit_tb.sv
module sensor_frame_parser_with_sum_check_unit_tb
  import sfpsc_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 1000000;
  localparam int unsigned PhaseWords = 310;
  localparam int unsigned NumPhases  = 5;

  typedef logic [ByteW-1:0] octet_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [CfgIdxW-1:0] cfg_index_i = '0;
  logic [ByteW-1:0]   cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  logic [ByteW-1:0]   rx_byte_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [LevelW-1:0]  source_level_o;
  logic [LevelW-1:0]  clean_level_o;
  logic [ByteW-1:0]   temp_reading_o;
  logic               sum_ok_o;

  int unsigned mismatch_cnt;
  int unsigned frames_pending;
  int unsigned cycle_cnt = 0;
  int unsigned words_sent = 0;
  bit          in_calm = 1'b0;
  bit          out_calm = 1'b0;
  bit          out_held = 1'b0;
  int unsigned hold_left = 0;
  octet_t      frame_buf[$];
  octet_t      start_val;
  octet_t      action_val;

  sensor_frame_parser_with_sum_check_unit dut (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_o,
    .rx_byte_i,
    .out_valid_o,
    .out_stall_i,
    .source_level_o,
    .clean_level_o,
    .temp_reading_o,
    .sum_ok_o
  );

  sfpsc_frame_checker u_chk (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_index_i,
    .cfg_wdata_i,
    .in_valid_i,
    .in_stall_i       (in_stall_o),
    .rx_byte_i,
    .out_valid_i      (out_valid_o),
    .out_stall_i,
    .source_level_i   (source_level_o),
    .clean_level_i    (clean_level_o),
    .temp_reading_i   (temp_reading_o),
    .sum_ok_i         (sum_ok_o),
    .mismatch_cnt_o   (mismatch_cnt),
    .frames_pending_o (frames_pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) begin
      return $urandom_range(1, 2);
    end else if (r < 95) begin
      return $urandom_range(3, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [LevelW-1:0] pick_level();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      return '0;
    end else if (r == 1) begin
      return '1;
    end
    return $urandom();
  endfunction

  // receiver back-pressure in segments of stall and no stall
  always @(posedge clk_i) begin
    if (hold_left == 0) begin
      if ($urandom_range(0, 19) == 0) begin
        out_calm = !out_calm;
      end
      out_held  = !out_calm && ($urandom_range(0, 2) == 0);
      hold_left = out_held ? idle_len() : $urandom_range(1, 12);
    end
    hold_left = hold_left - 1;
    out_stall_i <= out_held;
  end

  task automatic send_byte(input octet_t b);
    int unsigned gap;
    gap = (in_calm || $urandom_range(0, 99) < 55) ? 0 : idle_len();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(negedge clk_i); while (in_stall_o);
    @(posedge clk_i);
  endtask

  task automatic make_frame(input octet_t s, input octet_t a, input logic [LevelW-1:0] src,
                            input logic [LevelW-1:0] cln, input octet_t temp,
                            input logic [SumW-1:0] sum_flip);
    logic [SumW-1:0] sum;
    frame_buf.delete();
    frame_buf = {frame_buf, s};
    frame_buf = {frame_buf, a};
    for (int k = 3; k >= 0; k--) frame_buf = {frame_buf, src[8*k +: 8]};
    for (int k = 3; k >= 0; k--) frame_buf = {frame_buf, cln[8*k +: 8]};
    frame_buf = {frame_buf, temp};
    sum = '0;
    foreach (frame_buf[k]) sum = sum + SumW'(frame_buf[k]);
    sum = sum ^ sum_flip;
    frame_buf = {frame_buf, sum[15:8]};
    frame_buf = {frame_buf, sum[7:0]};
  endtask

  task automatic send_buf(input int unsigned n);
    for (int k = 0; k < n; k++) send_byte(frame_buf[k]);
    words_sent = words_sent + n;
  endtask

  task automatic write_config(input octet_t s, input octet_t a);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_START;
    cfg_wdata_i <= s;
    @(posedge clk_i);
    cfg_index_i <= CFG_ACTION;
    cfg_wdata_i <= a;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    start_val  = s;
    action_val = a;
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (frames_pending != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic random_phase(input int unsigned quota);
    int unsigned target;
    int unsigned kind;
    octet_t      bad;
    target = words_sent + quota;
    while (words_sent < target) begin
      if ($urandom_range(0, 9) == 0) begin
        in_calm = !in_calm;
      end
      kind = $urandom_range(0, 99);
      if (kind < 60) begin
        make_frame(start_val, action_val, pick_level(), pick_level(), octet_t'($urandom()),
                   '0);
        send_buf(13);
      end else if (kind < 75) begin
        make_frame(start_val, action_val, pick_level(), pick_level(), octet_t'($urandom()),
                   SumW'($urandom_range(1, 65535)));
        send_buf(13);
      end else if (kind < 85) begin
        bad = action_val ^ octet_t'($urandom_range(1, 255));
        make_frame(start_val, bad, '0, '0, '0, '0);
        send_buf(2);
      end else if (kind < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(octet_t'($urandom()));
      end else begin
        make_frame(start_val, action_val, pick_level(), pick_level(), octet_t'($urandom()),
                   '0);
        send_buf($urandom_range(3, 12));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: wrong start, wrong action, full-scale frame
    write_config(8'hFF, 8'h00);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    make_frame(8'hFF, 8'h00, '1, '1, 8'hFF, '0);
    send_buf(13);
    random_phase(PhaseWords);
    settle();

    for (int p = 1; p < NumPhases; p++) begin
      case (p)
        1:       write_config(8'h00, 8'h00);
        2:       write_config(8'hFF, 8'hFF);
        3:       write_config(8'h5A, 8'hA5);
        default: write_config(octet_t'($urandom()), octet_t'($urandom()));
      endcase
      random_phase(PhaseWords);
      settle();
    end

    repeat (8) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+hw/rtl
hw/rtl/sfpsc_pkg.sv
hw/rtl/sfpsc_cfg_regs.sv
hw/rtl/sfpsc_in_stage.sv
hw/rtl/sfpsc_parser.sv
hw/rtl/sensor_frame_parser_with_sum_check_unit.sv
dv/sfpsc_frame_checker.sv
dv/sensor_frame_parser_with_sum_check_unit_tb.sv
